[src/wstd_pkg.sv]
// ----------------------------------------------------------------------------
// wstd_pkg: shared types and constants for the WebSocket text decoder
// Parse phases, header field constants and the reset text opcode.
// ----------------------------------------------------------------------------
package wstd_pkg;

  localparam int MASK_KEY_BYTES = 4;
  localparam int KEY_IDX_W      = $clog2(MASK_KEY_BYTES);

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [63:0] LEN16_BYTES = 64'd2;
  localparam logic [63:0] LEN64_BYTES = 64'd8;
  localparam logic [63:0] KEY_BYTES   = 64'(MASK_KEY_BYTES);

  localparam logic [3:0] TEXT_OPCODE_RESET = 4'd1;

  // One-hot parse phases.
  typedef enum logic [5:0] {
    PH_OPCODE = 6'b000001,
    PH_LEN7   = 6'b000010,
    PH_LEN16  = 6'b000100,
    PH_LEN64  = 6'b001000,
    PH_MASK   = 6'b010000,
    PH_DATA   = 6'b100000
  } phase_t;

endpackage

[src/wstd_byte_if.sv]
// ----------------------------------------------------------------------------
// wstd_byte_if: raw frame byte channel
// Valid/ready channel carrying one received byte and its chunk end mark.
// ----------------------------------------------------------------------------
interface wstd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       chunk_last;

  modport source (output valid, output byte_in, output chunk_last, input ready);
  modport sink (input valid, input byte_in, input chunk_last, output ready);
endinterface

[src/wstd_char_if.sv]
// ----------------------------------------------------------------------------
// wstd_char_if: decoded character channel
// Valid/ready channel carrying one decoded Latin-1 character or chunk-end word.
// ----------------------------------------------------------------------------
interface wstd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_value;
  logic       has_char;
  logic       chunk_end;

  modport source (output valid, output char_value, output has_char, output chunk_end,
                  input ready);
  modport sink (input valid, input char_value, input has_char, input chunk_end,
                output ready);
endinterface

[src/websocket_frame_text_decoder_top.sv]
// ----------------------------------------------------------------------------
// websocket_frame_text_decoder_top: WebSocket frame parser with text fold
// Parses frame headers, unmasks payload and folds UTF-8 text to Latin-1.
// ----------------------------------------------------------------------------
// Usage:
//   frame  : sink channel, one raw frame-stream byte per word, with a
//            chunk_last mark on the last byte of each delivered chunk.
//   chars  : source channel, one word per decoded character and one for
//            every byte marked chunk_last (has_char tells them apart; a
//            character on a last byte gives a single word with both set).
//   wr_en/wr_data : write the text opcode; write only while idle.
// Path: a byte is held in the input register, then parsed, and its result
//   word lands in the output register, which presents it on chars until it
//   is taken.
// Throughput: one byte per cycle unless a byte that gives a word waits on
//   a stalled chars channel. Each byte takes a single pass of header/payload
//   logic whose longest path is the 64-bit payload counter step and length compare.
// Reset: parser expects an opcode byte, lengths, key and UTF-8 state clear,
//   text opcode returns to 1, both channels empty.
// Stall: while chars is stalled, bytes that give no word still advance; a
//   byte that gives a word waits in the input register, and the frame
//   channel drops ready once that register is full.
module websocket_frame_text_decoder_top (
  input  logic        clk,
  input  logic        rst,
  wstd_byte_if.sink   frame,
  wstd_char_if.source chars,
  input  logic        wr_en,
  input  logic [3:0]  wr_data
);
  import wstd_pkg::*;

  logic [3:0] text_opcode;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // Parser state.
  phase_t                    phase;
  logic                      frame_masked;
  logic [3:0]                frame_kind;
  logic [63:0]               payload_length;
  logic [63:0]               phase_count;
  logic [MASK_KEY_BYTES-1:0][7:0] mask_key;
  logic                      utf8_pending;
  logic [1:0]                lead_high_bits;

  phase_t                    phase_next;
  logic                      frame_masked_next;
  logic [3:0]                frame_kind_next;
  logic [63:0]               payload_length_next;
  logic [63:0]               phase_count_next;
  logic [MASK_KEY_BYTES-1:0][7:0] mask_key_next;
  logic                      utf8_pending_next;
  logic [1:0]                lead_high_bits_next;

  logic [63:0] count_inc;
  logic [63:0] len_shifted;
  logic [7:0]  data_byte;
  logic        got;
  logic [7:0]  ch;
  logic        emit;
  logic        s1_go;
  logic        out_free;

  // Output register.
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_has;
  logic       out_end;

  assign out_free    = !out_valid || chars.ready;
  assign emit        = got || s1_last;
  assign s1_go       = s1_valid && (!emit || out_free);
  assign frame.ready = !s1_valid || s1_go;

  assign count_inc   = phase_count + 64'd1;
  assign len_shifted = {payload_length[55:0], s1_byte};
  assign data_byte   = frame_masked ? (s1_byte ^ mask_key[phase_count[KEY_IDX_W-1:0]])
                                    : s1_byte;

  always_comb begin
    phase_next          = phase;
    frame_masked_next   = frame_masked;
    frame_kind_next     = frame_kind;
    payload_length_next = payload_length;
    phase_count_next    = phase_count;
    mask_key_next       = mask_key;
    utf8_pending_next   = utf8_pending;
    lead_high_bits_next = lead_high_bits;
    got                 = 1'b0;
    ch                  = 8'd0;

    unique case (phase)
      PH_LEN7: begin
        frame_masked_next = s1_byte[7];
        phase_count_next  = 64'd0;
        if (s1_byte[6:0] == LEN_EXT16) begin
          payload_length_next = 64'd0;
          phase_next          = PH_LEN16;
        end else if (s1_byte[6:0] == LEN_EXT64) begin
          payload_length_next = 64'd0;
          phase_next          = PH_LEN64;
        end else begin
          payload_length_next = {57'd0, s1_byte[6:0]};
          if (s1_byte[7]) begin
            phase_next = PH_MASK;
          end else if (s1_byte[6:0] == 7'd0) begin
            phase_next = PH_OPCODE;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_LEN16, PH_LEN64: begin
        payload_length_next = len_shifted;
        phase_count_next    = count_inc;
        if (count_inc == ((phase == PH_LEN16) ? LEN16_BYTES : LEN64_BYTES)) begin
          phase_count_next = 64'd0;
          if (frame_masked) begin
            phase_next = PH_MASK;
          end else if (len_shifted == 64'd0) begin
            phase_next = PH_OPCODE;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_MASK: begin
        mask_key_next[phase_count[KEY_IDX_W-1:0]] = s1_byte;
        phase_count_next = count_inc;
        if (count_inc >= KEY_BYTES) begin
          phase_count_next = 64'd0;
          phase_next       = (payload_length == 64'd0) ? PH_OPCODE : PH_DATA;
        end
      end
      PH_DATA: begin
        if (frame_kind == text_opcode) begin
          if (!utf8_pending) begin
            if (!data_byte[7]) begin
              got = 1'b1;
              ch  = data_byte;
            end else if (data_byte[7:5] == 3'b110) begin
              utf8_pending_next   = 1'b1;
              lead_high_bits_next = data_byte[1:0];
            end
          end else begin
            utf8_pending_next   = 1'b0;
            lead_high_bits_next = 2'd0;
            if (data_byte[7:6] == 2'b10) begin
              got = 1'b1;
              ch  = {lead_high_bits, data_byte[5:0]};
            end
          end
        end
        phase_count_next = count_inc;
        if (count_inc == payload_length) begin
          phase_count_next = 64'd0;
          phase_next       = PH_OPCODE;
        end
      end
      default: begin
        frame_kind_next  = s1_byte[3:0];
        phase_count_next = 64'd0;
        phase_next       = PH_LEN7;
      end
    endcase

    // Restart UTF-8 folding at each payload start.
    if (phase_next == PH_DATA && phase != PH_DATA) begin
      utf8_pending_next   = 1'b0;
      lead_high_bits_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_opcode <= TEXT_OPCODE_RESET;
    end else if (wr_en) begin
      text_opcode <= wr_data;
    end
  end

  // Input register: hold a byte until the parser can take it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame.ready) begin
      s1_valid <= frame.valid;
    end
    if (frame.valid && frame.ready) begin
      s1_byte <= frame.byte_in;
      s1_last <= frame.chunk_last;
    end
  end

  // Parser state: advance once per parsed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_OPCODE;
      frame_masked   <= 1'b0;
      frame_kind     <= 4'd0;
      payload_length <= 64'd0;
      phase_count    <= 64'd0;
      mask_key       <= '0;
      utf8_pending   <= 1'b0;
      lead_high_bits <= 2'd0;
    end else if (s1_go) begin
      phase          <= phase_next;
      frame_masked   <= frame_masked_next;
      frame_kind     <= frame_kind_next;
      payload_length <= payload_length_next;
      phase_count    <= phase_count_next;
      mask_key       <= mask_key_next;
      utf8_pending   <= utf8_pending_next;
      lead_high_bits <= lead_high_bits_next;
    end
  end

  // Output register: load a result word, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid <= 1'b1;
    end else if (chars.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_go && emit) begin
      out_char <= ch;
      out_has  <= got;
      out_end  <= s1_last;
    end
  end

  assign chars.valid      = out_valid;
  assign chars.char_value = out_char;
  assign chars.has_char   = out_has;
  assign chars.chunk_end  = out_end;

endmodule

[tb/tb_websocket_frame_text_decoder_top.sv]
// ----------------------------------------------------------------------------
// tb_websocket_frame_text_decoder_top: frame parser and text fold testbench
// Feeds WebSocket frame bytes through the frame channel and predicts every
// character and chunk-end word in the testbench. Each word on the char
// channel is checked field by field, in order. The run starts with hand-built
// frames for the corner cases, then sends random well-formed frames under
// several text opcode settings; both channels stall at random but in one run.
// ----------------------------------------------------------------------------
module tb_websocket_frame_text_decoder_top;
  import wstd_pkg::*;

  // Cycles to let a byte that gives no word leave the pipeline.
  localparam int SETTLE_CYCLES  = 8;
  // Cycles with no word moving on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cap on printed mismatch lines; all mismatches are still counted.
  localparam int REPORT_CAP     = 40;

  // Parser position, tracked by the predictor.
  typedef enum int {
    HDR_OPCODE,
    HDR_LEN7,
    HDR_LEN16,
    HDR_LEN64,
    HDR_KEY,
    PAYLOAD
  } parse_t;

  typedef enum int {
    LEN_SHORT,
    LEN_FORM16,
    LEN_FORM64
  } len_form_t;

  typedef struct packed {
    logic [7:0] char_value;
    logic       has_char;
    logic       chunk_end;
  } char_word_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       wr_en;
  logic [3:0] wr_data;

  wstd_byte_if frame_if ();
  wstd_char_if char_if ();

  websocket_frame_text_decoder_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame_if),
    .chars   (char_if),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: mirrors the decoder after every accepted byte.
  logic [3:0]  text_op        = TEXT_OPCODE_RESET;
  parse_t      parse_st       = HDR_OPCODE;
  logic        frm_masked     = 1'b0;
  logic [3:0]  frm_kind       = '0;
  logic [63:0] frm_len        = '0;
  logic [63:0] step_cnt       = '0;
  logic [7:0]  frm_key [MASK_KEY_BYTES] = '{default: '0};
  logic        utf8_lead_seen = 1'b0;
  logic [1:0]  lead_bits      = '0;

  // Words the decoder still owes, oldest first.
  char_word_t pending_chars[$];

  // Both sides stop idling while this is set.
  bit steady = 1'b0;

  int bytes_sent;
  int frames_sent;
  int words_checked;
  int chars_seen;
  int ends_seen;
  int mismatches;
  int quiet_cycles;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Move to a new parse phase; a payload always starts in single-byte state.
  function automatic void enter_state(parse_t p);
    if (p == PAYLOAD) begin
      utf8_lead_seen = 1'b0;
      lead_bits      = '0;
    end
    parse_st = p;
    step_cnt = '0;
  endfunction

  // After the length: a key follows if masked, otherwise payload or next frame.
  function automatic void close_length();
    if (frm_masked) begin
      enter_state(HDR_KEY);
    end else begin
      enter_state(frm_len == 0 ? HDR_OPCODE : PAYLOAD);
    end
  endfunction

  // Advance the predicted parser by one byte and queue the word it gives.
  function automatic void predict_byte(logic [7:0] b, logic last);
    logic       got;
    logic [7:0] ch;
    logic [7:0] d;
    char_word_t owed;
    got = 1'b0;
    ch  = '0;
    case (parse_st)
      HDR_LEN7: begin
        frm_masked = b[7];
        if (b[6:0] == LEN_EXT16) begin
          frm_len = '0;
          enter_state(HDR_LEN16);
        end else if (b[6:0] == LEN_EXT64) begin
          frm_len = '0;
          enter_state(HDR_LEN64);
        end else begin
          frm_len = 64'(b[6:0]);
          close_length();
        end
      end
      HDR_LEN16, HDR_LEN64: begin
        frm_len  = (frm_len << 8) + 64'(b);
        step_cnt = step_cnt + 1;
        if (step_cnt == (parse_st == HDR_LEN16 ? LEN16_BYTES : LEN64_BYTES)) close_length();
      end
      HDR_KEY: begin
        frm_key[int'(step_cnt % KEY_BYTES)] = b;
        step_cnt = step_cnt + 1;
        if (step_cnt >= KEY_BYTES) enter_state(frm_len == 0 ? HDR_OPCODE : PAYLOAD);
      end
      PAYLOAD: begin
        if (frm_kind == text_op) begin
          d = frm_masked ? (b ^ frm_key[int'(step_cnt % KEY_BYTES)]) : b;
          if (!utf8_lead_seen) begin
            if (!d[7]) begin
              ch  = d;
              got = 1'b1;
            end else if (d[7:5] == 3'b110) begin
              utf8_lead_seen = 1'b1;
              lead_bits      = d[1:0];
            end
          end else begin
            // Pending lead: only 10xxxxxx completes it, anything else is dropped.
            utf8_lead_seen = 1'b0;
            if (d[7:6] == 2'b10) begin
              ch  = {lead_bits, d[5:0]};
              got = 1'b1;
            end
            lead_bits = '0;
          end
        end
        step_cnt = step_cnt + 1;
        if (step_cnt == frm_len) enter_state(HDR_OPCODE);
      end
      default: begin
        frm_kind = b[3:0];
        enter_state(HDR_LEN7);
      end
    endcase
    if (got || last) begin
      owed          = '{char_value: ch, has_char: got, chunk_end: last};
      pending_chars = {pending_chars, owed};
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mark roughly one byte in eight as the end of a chunk.
  function automatic logic next_last();
    return ($urandom_range(7) == 0);
  endfunction

  // Offer one byte; hold it until the decoder takes it, then predict.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(99) < 10) begin
      frame_if.valid <= 1'b0;
      @(posedge clk);
    end
    frame_if.valid      <= 1'b1;
    frame_if.byte_in    <= b;
    frame_if.chunk_last <= last;
    do @(posedge clk); while (frame_if.ready !== 1'b1);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  // Drop valid, wait for every owed word, then let the pipeline settle.
  task automatic wait_drained();
    frame_if.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the text opcode while the decoder is idle.
  task automatic write_text_opcode(input logic [3:0] value);
    wait_drained();
    wr_en   <= 1'b1;
    wr_data <= value;
    @(posedge clk);
    text_op = value;
    wr_en   <= 1'b0;
  endtask

  // Build one frame: header, optional key, then `body` payload bytes.
  // Payload is mostly ASCII and well-formed two-byte sequences, with some noise.
  task automatic send_frame(input logic [3:0] kind, input bit masked, input len_form_t form,
                            input logic [63:0] len, input int body);
    logic [7:0] key [MASK_KEY_BYTES];
    logic [7:0] plain;
    bit         owe_cont;
    int         i;
    frames_sent++;
    send_byte({4'($urandom), kind}, next_last());
    case (form)
      LEN_SHORT: begin
        send_byte({masked, len[6:0]}, next_last());
      end
      LEN_FORM16: begin
        send_byte({masked, LEN_EXT16}, next_last());
        send_byte(len[15:8], next_last());
        send_byte(len[7:0], next_last());
      end
      default: begin
        send_byte({masked, LEN_EXT64}, next_last());
        for (i = 7; i >= 0; i--) send_byte(8'(len >> (8 * i)), next_last());
      end
    endcase
    if (masked) begin
      for (i = 0; i < MASK_KEY_BYTES; i++) begin
        key[i] = 8'($urandom);
        send_byte(key[i], next_last());
      end
    end
    owe_cont = 1'b0;
    for (i = 0; i < body; i++) begin
      if (owe_cont && $urandom_range(99) < 85) begin
        plain = {2'b10, 6'($urandom)};
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3: plain = {1'b0, 7'($urandom)};
          4, 5, 6:    plain = {3'b110, 5'($urandom)};
          default:    plain = 8'($urandom);
        endcase
      end
      owe_cont = (plain[7:5] == 3'b110);
      if (masked) plain = plain ^ key[i % MASK_KEY_BYTES];
      send_byte(plain, next_last());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Unmasked text frame with a 16-bit length: the byte extremes, a bad
  // continuation, a chunk end with no character, and a character on the
  // last byte of a chunk.
  task automatic test_plain_text_frame();
    send_byte(8'h81, 1'b0);
    send_byte({1'b0, LEN_EXT16}, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h00, 1'b0);   // ASCII zero
    send_byte(8'hC3, 1'b0);   // lead
    send_byte(8'h7F, 1'b0);   // not a continuation: drop both
    send_byte(8'hC3, 1'b1);   // lead on a chunk end: end word only
    send_byte(8'hBF, 1'b1);   // completes to 0xFF on a chunk end
  endtask

  // Masked frame that ends with a lead pending, an empty masked control
  // frame, then a text frame whose first byte is a stray continuation: it
  // must be dropped because the UTF-8 state restarts with each payload.
  task automatic test_masked_and_empty_frames();
    send_byte(8'h81, 1'b0);
    send_byte(8'h81, 1'b0);   // masked, one payload byte
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hC2 ^ 8'hFF, 1'b0);
    send_byte(8'h8A, 1'b0);   // non-text kind
    send_byte(8'h80, 1'b0);   // masked, empty payload
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);   // key byte closes a chunk
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h80, 1'b0);   // stray continuation
    send_byte(8'hFF, 1'b1);   // not a two-byte lead: dropped, end word only
  endtask

  // Random well-formed frames under one text opcode setting.
  task automatic test_random_frames(input logic [3:0] opcode, input int byte_goal,
                                    input bit no_gaps);
    int         first_byte;
    int         len;
    logic [3:0] kind;
    bit         masked;
    len_form_t  form;
    write_text_opcode(opcode);
    steady     = no_gaps;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < byte_goal) begin
      kind   = ($urandom_range(9) < 7) ? opcode : 4'($urandom);
      masked = 1'($urandom_range(1));
      case ($urandom_range(9))
        0, 1:    form = LEN_FORM16;
        2:       form = LEN_FORM64;
        default: form = LEN_SHORT;
      endcase
      // Keep most payloads short; an extended form now and then carries a long one.
      if (form != LEN_SHORT && $urandom_range(19) == 0) len = $urandom_range(126, 400);
      else len = $urandom_range(0, 24);
      send_frame(kind, masked, form, 64'(len), len);
    end
    steady = 1'b0;
  endtask

  // Maximum 64-bit length: the frame never ends, so leave it last.
  task automatic test_endless_payload();
    send_frame(text_op, 1'b1, LEN_FORM64, '1, 24);
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string what);
    if (mismatches < REPORT_CAP) $display("MISMATCH at word %0d: %s", words_checked, what);
    mismatches++;
  endtask

  // Take each word off the char channel and compare it with the oldest
  // prediction; drive ready with random stalls.
  always @(posedge clk) begin
    char_word_t want;
    if (rst) begin
      char_if.ready <= 1'b0;
    end else begin
      if (char_if.valid === 1'b1 && char_if.ready === 1'b1) begin
        words_checked++;
        if (pending_chars.size() == 0) begin
          flag_mismatch($sformatf("unexpected word char_value=%02h has_char=%0b chunk_end=%0b",
                                  char_if.char_value, char_if.has_char, char_if.chunk_end));
        end else begin
          want = pending_chars.pop_front();
          if (char_if.has_char !== want.has_char)
            flag_mismatch($sformatf("has_char %0b, expected %0b", char_if.has_char, want.has_char));
          if (char_if.char_value !== want.char_value)
            flag_mismatch($sformatf("char_value %02h, expected %02h",
                                    char_if.char_value, want.char_value));
          if (char_if.chunk_end !== want.chunk_end)
            flag_mismatch($sformatf("chunk_end %0b, expected %0b",
                                    char_if.chunk_end, want.chunk_end));
          if (want.has_char) chars_seen++;
          if (want.chunk_end) ends_seen++;
        end
      end
      char_if.ready <= steady || ($urandom_range(99) >= 10);
    end
  end

  // Abandon the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((frame_if.valid === 1'b1 && frame_if.ready === 1'b1) ||
        (char_if.valid === 1'b1 && char_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles, %0d words still owed",
               WATCHDOG_LIMIT, pending_chars.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst                 <= 1'b1;
    wr_en               <= 1'b0;
    wr_data             <= '0;
    frame_if.valid      <= 1'b0;
    frame_if.byte_in    <= '0;
    frame_if.chunk_last <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed frames run with the reset text opcode.
    test_plain_text_frame();
    test_masked_and_empty_frames();

    // Random frames across opcode settings; the 15 phase runs without stalls.
    test_random_frames(4'd0, 190, 1'b0);
    test_random_frames(4'd15, 190, 1'b1);
    test_random_frames(4'($urandom_range(2, 14)), 190, 1'b0);
    test_random_frames(TEXT_OPCODE_RESET, 190, 1'b0);

    test_endless_payload();
    wait_drained();

    $display("Sent %0d bytes in %0d frames over text opcodes 1, 0, 15, random and 1 again",
             bytes_sent, frames_sent);
    $display("Checked %0d words: %0d characters, %0d chunk ends, %0d mismatches",
             words_checked, chars_seen, ends_seen, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
